[hdl/cpid_pkg.sv]
`timescale 1ns / 1ps
package cpid_pkg;

   localparam int unsigned AddrWidth = 5;

   localparam logic [AddrWidth-1:0] AddrOuterKp    = 5'd0;
   localparam logic [AddrWidth-1:0] AddrOuterKi    = 5'd4;
   localparam logic [AddrWidth-1:0] AddrInnerKp    = 5'd8;
   localparam logic [AddrWidth-1:0] AddrInnerKi    = 5'd12;
   localparam logic [AddrWidth-1:0] AddrInnerKd    = 5'd16;
   localparam logic [AddrWidth-1:0] AddrDriveLimit = 5'd20;

   localparam logic signed [24:0] OuterSep   = 25'sd25600;
   localparam logic signed [24:0] OuterClamp = 25'sd768000;
   localparam logic signed [25:0] InnerSep   = 26'sd102400;
   localparam logic signed [25:0] InnerClamp = 26'sd384000;

   // datapath operation selected by the controller
   typedef enum logic [3:0] {
      OP_NONE   = 4'd0,
      OP_ERR1   = 4'd1,  // e1, outer integral update
      OP_MUL_A  = 4'd2,  // acc = e1*outer_kp
      OP_MUL_B  = 4'd3,  // acc += oint*outer_ki
      OP_SP     = 4'd4,  // sp = acc/256 saturated, e2, inner integral
      OP_MUL_C  = 4'd5,  // acc = e2*inner_kp
      OP_MUL_D  = 4'd6,  // acc += iint*inner_ki
      OP_MUL_E  = 4'd7,  // num = (prev_rate-rate)*inner_kd
      OP_DIV_LD = 4'd8,  // load divider
      OP_DIV_ST = 4'd9,  // one restoring step
      OP_DIV_FX = 4'd10, // add signed quotient to acc
      OP_OUT    = 4'd11  // clamp, update history
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic dt_zero;
   } sts_type;

   typedef enum logic [10:0] {
      ST_IDLE = 11'b00000000001,
      ST_E1   = 11'b00000000010,
      ST_MA   = 11'b00000000100,
      ST_MB   = 11'b00000001000,
      ST_SP   = 11'b00000010000,
      ST_MC   = 11'b00000100000,
      ST_MD   = 11'b00001000000,
      ST_ME   = 11'b00010000000,
      ST_DIV  = 11'b00100000000,
      ST_FIX  = 11'b01000000000,
      ST_OUT  = 11'b10000000000
   } state_type;

endpackage

[hdl/cpid_ctrl.sv]
`timescale 1ns / 1ps
module cpid_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              out_busy,
   input  cpid_pkg::sts_type sts,
   output cpid_pkg::cmd_type cmd,
   output logic              idle
);

   cpid_pkg::state_type state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpid_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd.op   = cpid_pkg::OP_NONE;
      idle     = 1'b0;
      unique case (state_ff)
         cpid_pkg::ST_IDLE: begin
            idle = 1'b1;
            if (start) state_in = cpid_pkg::ST_E1;
         end
         cpid_pkg::ST_E1: begin
            cmd.op = cpid_pkg::OP_ERR1; state_in = cpid_pkg::ST_MA;
         end
         cpid_pkg::ST_MA: begin
            cmd.op = cpid_pkg::OP_MUL_A; state_in = cpid_pkg::ST_MB;
         end
         cpid_pkg::ST_MB: begin
            cmd.op = cpid_pkg::OP_MUL_B; state_in = cpid_pkg::ST_SP;
         end
         cpid_pkg::ST_SP: begin
            cmd.op = cpid_pkg::OP_SP; state_in = cpid_pkg::ST_MC;
         end
         cpid_pkg::ST_MC: begin
            cmd.op = cpid_pkg::OP_MUL_C; state_in = cpid_pkg::ST_MD;
         end
         cpid_pkg::ST_MD: begin
            cmd.op = cpid_pkg::OP_MUL_D; state_in = cpid_pkg::ST_ME;
         end
         cpid_pkg::ST_ME: begin
            cmd.op = cpid_pkg::OP_MUL_E;
            if (sts.dt_zero) begin
               state_in = cpid_pkg::ST_OUT;
            end else begin
               state_in = cpid_pkg::ST_DIV;
               cnt_in   = '0;
            end
         end
         cpid_pkg::ST_DIV: begin
            if (cnt_ff == 6'd0) cmd.op = cpid_pkg::OP_DIV_LD;
            else                cmd.op = cpid_pkg::OP_DIV_ST;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd41) state_in = cpid_pkg::ST_FIX;
         end
         cpid_pkg::ST_FIX: begin
            cmd.op = cpid_pkg::OP_DIV_FX; state_in = cpid_pkg::ST_OUT;
         end
         cpid_pkg::ST_OUT: begin
            if (!out_busy) begin
               cmd.op   = cpid_pkg::OP_OUT;
               state_in = cpid_pkg::ST_IDLE;
            end
         end
         default: state_in = cpid_pkg::ST_IDLE;
      endcase
   end

endmodule

[hdl/cpid_dp.sv]
`timescale 1ns / 1ps
module cpid_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic signed [23:0]  measured_angle,
   input  logic signed [23:0]  target_angle,
   input  logic signed [23:0]  body_rate,
   input  logic [31:0]         tick_now,
   input  logic signed [15:0]  outer_kp,
   input  logic signed [15:0]  outer_ki,
   input  logic signed [15:0]  inner_kp,
   input  logic signed [15:0]  inner_ki,
   input  logic signed [15:0]  inner_kd,
   input  logic [14:0]         drive_limit,
   input  cpid_pkg::cmd_type   cmd,
   output cpid_pkg::sts_type   sts,
   output logic signed [15:0]  drive,
   output logic                clamped
);

   logic signed [23:0] meas_ff, targ_ff, rate_ff;
   logic [31:0] tick_ff;
   logic signed [23:0] oint_ff, oint_in, iint_ff, iint_in, prate_ff;
   logic [31:0] ptick_ff;
   logic signed [24:0] e1_ff;
   logic signed [25:0] e2_ff;
   logic signed [47:0] acc_ff;
   logic signed [24:0] mul_a;
   logic signed [15:0] mul_b;
   logic signed [40:0] prod;
   logic signed [40:0] num_ff;
   // divider: magnitude dividend 41 bits, 32-bit divisor
   logic [40:0] dq_ff;
   logic [32:0] rem_ff;
   logic        neg_ff;
   logic [31:0] dt;
   logic [33:0] trial;
   logic signed [15:0] drive_ff;
   logic               clamped_ff;

   logic signed [24:0] e1_c;
   logic signed [25:0] osum;
   logic signed [39:0] spq;
   logic signed [23:0] sp;
   logic signed [25:0] e2_c;
   logic signed [26:0] isum;
   logic signed [47:0] lim;
   logic signed [41:0] qs;

   assign dt          = tick_ff - ptick_ff;
   assign sts.dt_zero = (dt == 32'd0);
   assign drive       = drive_ff;
   assign clamped     = clamped_ff;

   always_comb begin
      unique case (cmd.op)
         cpid_pkg::OP_MUL_A: begin mul_a = e1_ff; mul_b = outer_kp; end
         cpid_pkg::OP_MUL_B: begin mul_a = 25'(oint_ff); mul_b = outer_ki; end
         cpid_pkg::OP_MUL_C: begin mul_a = 25'(e2_ff); mul_b = inner_kp; end
         cpid_pkg::OP_MUL_D: begin mul_a = 25'(iint_ff); mul_b = inner_ki; end
         cpid_pkg::OP_MUL_E: begin
            mul_a = 25'(prate_ff) - 25'(rate_ff); mul_b = inner_kd;
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
      prod = 41'(mul_a) * 41'(mul_b);
   end

   always_comb begin
      e1_c = 25'(targ_ff) - 25'(meas_ff);
      if (e1_c > -cpid_pkg::OuterSep && e1_c < cpid_pkg::OuterSep)
         osum = 26'(oint_ff) + 26'(e1_c);
      else
         osum = '0;
      if (osum > 26'(cpid_pkg::OuterClamp))       oint_in = 24'(cpid_pkg::OuterClamp);
      else if (osum < -26'(cpid_pkg::OuterClamp)) oint_in = 24'(-cpid_pkg::OuterClamp);
      else                                        oint_in = 24'(osum);

      // truncate toward zero divide by 256
      spq = 40'((acc_ff[47] ? acc_ff + 48'sd255 : acc_ff) >>> 8);
      if (spq > 40'sd8388607)       sp = 24'sh7fffff;
      else if (spq < -40'sd8388608) sp = 24'sh800000;
      else                          sp = 24'(spq);
      e2_c = 26'(sp) - 26'(rate_ff);
      if (e2_c > -cpid_pkg::InnerSep && e2_c < cpid_pkg::InnerSep)
         isum = 27'(iint_ff) + 27'(e2_c);
      else
         isum = '0;
      if (isum > 27'(cpid_pkg::InnerClamp))       iint_in = 24'(cpid_pkg::InnerClamp);
      else if (isum < -27'(cpid_pkg::InnerClamp)) iint_in = 24'(-cpid_pkg::InnerClamp);
      else                                        iint_in = 24'(isum);

      trial = {rem_ff, dq_ff[40]} - {2'b00, dt};
      qs    = neg_ff ? -$signed({1'b0, dq_ff}) : $signed({1'b0, dq_ff});
      lim   = $signed({17'd0, drive_limit, 16'd0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oint_ff    <= '0;
         iint_ff    <= '0;
         prate_ff   <= '0;
         ptick_ff   <= '0;
         drive_ff   <= '0;
         clamped_ff <= 1'b0;
      end else begin
         if (load) begin
            meas_ff <= measured_angle;
            targ_ff <= target_angle;
            rate_ff <= body_rate;
            tick_ff <= tick_now;
         end
         unique case (cmd.op)
            cpid_pkg::OP_ERR1: begin e1_ff <= e1_c; oint_ff <= oint_in; end
            cpid_pkg::OP_MUL_A: acc_ff <= 48'(prod);
            cpid_pkg::OP_MUL_B: acc_ff <= acc_ff + 48'(prod);
            cpid_pkg::OP_SP: begin e2_ff <= e2_c; iint_ff <= iint_in; end
            cpid_pkg::OP_MUL_C: acc_ff <= 48'(prod);
            cpid_pkg::OP_MUL_D: acc_ff <= acc_ff + 48'(prod);
            cpid_pkg::OP_MUL_E: num_ff <= prod;
            cpid_pkg::OP_DIV_LD: begin
               neg_ff <= num_ff[40];
               dq_ff  <= num_ff[40] ? 41'(-num_ff) : 41'(num_ff);
               rem_ff <= '0;
            end
            cpid_pkg::OP_DIV_ST: begin
               if (!trial[33]) begin
                  rem_ff <= trial[32:0];
                  dq_ff  <= {dq_ff[39:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[31:0], dq_ff[40]};
                  dq_ff  <= {dq_ff[39:0], 1'b0};
               end
            end
            cpid_pkg::OP_DIV_FX: acc_ff <= acc_ff + 48'(qs);
            cpid_pkg::OP_OUT: begin
               if (acc_ff > lim) begin
                  drive_ff <= $signed({1'b0, drive_limit}); clamped_ff <= 1'b1;
               end else if (acc_ff < -lim) begin
                  drive_ff <= -$signed({1'b0, drive_limit}); clamped_ff <= 1'b1;
               end else begin
                  drive_ff <= 16'((acc_ff[47] ? acc_ff + 48'sd65535 : acc_ff) >>> 16);
                  clamped_ff <= 1'b0;
               end
               prate_ff <= rate_ff;
               ptick_ff <= tick_ff;
            end
            default: ;
         endcase
      end
   end

endmodule

[hdl/cascade_pid_dual_integral_axis.sv]
`timescale 1ns / 1ps
// cascade pi(d) for one gimbal axis: an angle pi loop with integral separation and
// clamp feeds the rate setpoint of a rate pi loop with a d term on the rate change
// divided by the tick delta; drive is clamped to +-drive_limit. one item is in work
// at a time, set by the shared 16x25 multiplier (five products) and the 41-step
// restoring divider, which is skipped when the tick delta is zero. the result sits in
// an output register; the next item is taken once the controller returns to idle, which
// it does when it writes a result, and it waits until the previous result has been taken.
module cascade_pid_dual_integral_axis (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [23:0]                req_measured_angle,
   input  logic signed [23:0]                req_target_angle,
   input  logic signed [23:0]                req_body_rate,
   input  logic [31:0]                       req_tick_now,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [15:0]                rsp_drive,
   output logic                              rsp_clamped,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cpid_pkg::AddrWidth-1:0]    csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   logic signed [15:0] outer_kp_ff, outer_ki_ff, inner_kp_ff, inner_ki_ff, inner_kd_ff;
   logic [14:0] drive_limit_ff;
   logic rsp_valid_ff;
   logic idle, start, wr;
   cpid_pkg::cmd_type cmd;
   cpid_pkg::sts_type sts;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   // gain registers
   always_ff @(posedge clock) begin
      if (reset) begin
         outer_kp_ff    <= -16'sd3840;
         outer_ki_ff    <= -16'sd102;
         inner_kp_ff    <= -16'sd1664;
         inner_ki_ff    <= '0;
         inner_kd_ff    <= '0;
         drive_limit_ff <= 15'd3000;
      end else if (wr) begin
         unique case (csr_paddr)
            cpid_pkg::AddrOuterKp:    outer_kp_ff    <= csr_pwdata[15:0];
            cpid_pkg::AddrOuterKi:    outer_ki_ff    <= csr_pwdata[15:0];
            cpid_pkg::AddrInnerKp:    inner_kp_ff    <= csr_pwdata[15:0];
            cpid_pkg::AddrInnerKi:    inner_ki_ff    <= csr_pwdata[15:0];
            cpid_pkg::AddrInnerKd:    inner_kd_ff    <= csr_pwdata[15:0];
            cpid_pkg::AddrDriveLimit: drive_limit_ff <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (csr_paddr)
         cpid_pkg::AddrOuterKp:    csr_prdata = 32'(outer_kp_ff);
         cpid_pkg::AddrOuterKi:    csr_prdata = 32'(outer_ki_ff);
         cpid_pkg::AddrInnerKp:    csr_prdata = 32'(inner_kp_ff);
         cpid_pkg::AddrInnerKi:    csr_prdata = 32'(inner_ki_ff);
         cpid_pkg::AddrInnerKd:    csr_prdata = 32'(inner_kd_ff);
         cpid_pkg::AddrDriveLimit: csr_prdata = {17'd0, drive_limit_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   // item accepted only while the controller is idle and out of reset
   assign req_stall = reset || !idle;
   assign start     = req_valid && !req_stall;

   // result handshake: valid set when the datapath writes the output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.op == cpid_pkg::OP_OUT) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end
   assign rsp_valid = rsp_valid_ff;

   cpid_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_busy (rsp_valid_ff && rsp_stall),
      .sts      (sts),
      .cmd      (cmd),
      .idle     (idle)
   );

   cpid_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .load           (start),
      .measured_angle (req_measured_angle),
      .target_angle   (req_target_angle),
      .body_rate      (req_body_rate),
      .tick_now       (req_tick_now),
      .outer_kp       (outer_kp_ff),
      .outer_ki       (outer_ki_ff),
      .inner_kp       (inner_kp_ff),
      .inner_ki       (inner_ki_ff),
      .inner_kd       (inner_kd_ff),
      .drive_limit    (drive_limit_ff),
      .cmd            (cmd),
      .sts            (sts),
      .drive          (rsp_drive),
      .clamped        (rsp_clamped)
   );

endmodule
